// ----- sv/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Box blur package
// Shared constants, register indexes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int MAX_RADIUS_DEF = 7;
    localparam int MAX_WIDTH_DEF  = 1024;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int CFG_DATA_W = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic win_start;
        logic rd_issue;
        logic acc;
        logic div_start;
        logic div_step;
        logic out_fire;
    } bbc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic win_ready;
        logic win_last;
        logic div_last;
    } bbc_sts_t;

endpackage

// ----- sv/bbc_if.sv -----
// ----------------------------------------------------------------------------
// Box blur stream interfaces
// Pixel input channel and averaged result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bbc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic [7:0] pix_alpha;
    logic       drain;

    modport source (output valid, pix_red, pix_green, pix_blue, pix_alpha, drain,
                    input ready);
    modport sink   (input valid, pix_red, pix_green, pix_blue, pix_alpha, drain,
                    output ready);
endinterface

interface bbc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                    output ready);
endinterface

// ----- sv/bbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Box blur controller
// Sequences one beat: store, window check, window walk, division, result.
// ----------------------------------------------------------------------------
module bbc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bbc_pkg::bbc_sts_t sts,
    output bbc_pkg::bbc_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ADDR,
        S_ACC,
        S_DINIT,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CHECK;
            S_CHECK: state_next = sts.win_ready ? S_ADDR : S_IDLE;
            S_ADDR:  state_next = S_ACC;
            S_ACC:   state_next = sts.win_last ? S_DINIT : S_ADDR;
            S_DINIT: state_next = S_DIV;
            S_DIV:   if (sts.div_last) state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        out_valid     = (state_reg == S_OUT);
        cmd.accept    = (state_reg == S_IDLE) && in_valid;
        cmd.win_start = (state_reg == S_CHECK) && sts.win_ready;
        cmd.rd_issue  = (state_reg == S_ADDR);
        cmd.acc       = (state_reg == S_ACC);
        cmd.div_start = (state_reg == S_DINIT);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.out_fire  = (state_reg == S_OUT) && out_ready;
    end

endmodule

// ----- sv/bbc_dp.sv -----
// ----------------------------------------------------------------------------
// Box blur datapath
// Line store, frame positions, window accumulators and serial dividers.
// ----------------------------------------------------------------------------
module bbc_dp
#(
    parameter int MAX_RADIUS = bbc_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [31:0]                   in_pix,
    input  logic                          in_drain,
    input  bbc_pkg::bbc_cmd_t             cmd,
    output bbc_pkg::bbc_sts_t             sts,
    output logic [31:0]                   res_pix,
    output logic                          res_end
);

    localparam int LS_ROWS = 3 * MAX_RADIUS + 2;
    localparam int SL_W    = $clog2(LS_ROWS);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ADDR_W  = $clog2(LS_ROWS * MAX_WIDTH);
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int SIDE    = 2 * MAX_RADIUS + 1;
    localparam int CNT_W   = $clog2(SIDE * SIDE + 1);
    localparam int SUM_W   = $clog2(SIDE * SIDE * 255 + 1);
    localparam int DC_W    = $clog2(SUM_W);

    // Configuration registers.
    logic [2:0]  rad_reg;
    logic [10:0] fw_reg;
    logic [15:0] fh_reg;

    // Frame positions.
    logic [15:0]      in_row_reg, out_row_reg;
    logic [COL_W-1:0] in_col_reg, out_col_reg;
    logic [SL_W-1:0]  in_slot_reg, out_slot_reg;
    logic             in_done_reg;

    // Window walk.
    logic [15:0]      win_y_reg, ry_reg;
    logic [COL_W-1:0] win_x_reg, rx_reg, x0_reg;
    logic [SL_W-1:0]  win_slot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sum_reg [4];
    logic [31:0]      rd_reg;

    // Division.
    logic [SUM_W-1:0] dvd_reg [4];
    logic [CNT_W-1:0] rem_reg [4];
    logic [DC_W-1:0]  dc_reg;

    logic [31:0] mem [LS_ROWS * MAX_WIDTH];

    // Effective settings.
    logic [RAD_W-1:0] r_eff;
    logic [COL_W-1:0] w_m1;
    logic [15:0]      h_m1;

    always_comb
    begin
        r_eff = (int'(rad_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(rad_reg);
        if (fw_reg == 11'd0)
            w_m1 = '0;
        else if (int'(fw_reg) > MAX_WIDTH)
            w_m1 = COL_W'(MAX_WIDTH - 1);
        else
            w_m1 = COL_W'(fw_reg - 11'd1);
        h_m1 = (fh_reg == 16'd0) ? 16'd0 : fh_reg - 16'd1;
    end

    // Window bounds of the next output pixel.
    logic [16:0]      ry_sum;
    logic [COL_W:0]   rx_sum;
    logic [15:0]      ry;
    logic [COL_W-1:0] rx, x0;
    logic [15:0]      dy, y0;
    logic [SL_W:0]    slot_dif;
    logic [SL_W-1:0]  slot0;

    always_comb
    begin
        ry_sum = 17'(out_row_reg) + 17'(r_eff);
        ry     = (ry_sum > 17'(h_m1)) ? h_m1 : ry_sum[15:0];
        rx_sum = (COL_W + 1)'(out_col_reg) + (COL_W + 1)'(r_eff);
        rx     = (rx_sum > (COL_W + 1)'(w_m1)) ? w_m1 : rx_sum[COL_W-1:0];
        x0     = ((COL_W + 1)'(out_col_reg) > (COL_W + 1)'(r_eff)) ?
                 COL_W'((COL_W + 1)'(out_col_reg) - (COL_W + 1)'(r_eff)) : '0;
        dy     = (out_row_reg > 16'(r_eff)) ? 16'(r_eff) : out_row_reg;
        y0     = out_row_reg - dy;
        slot_dif = (SL_W + 1)'(out_slot_reg) - (SL_W + 1)'(dy);
        slot0  = slot_dif[SL_W] ? SL_W'(slot_dif + (SL_W + 1)'(LS_ROWS))
                                : slot_dif[SL_W-1:0];
        sts.win_ready = in_done_reg || (in_row_reg > ry) ||
                        ((in_row_reg == ry) && (in_col_reg > rx));
        sts.win_last  = (win_x_reg == rx_reg) && (win_y_reg == ry_reg);
        sts.div_last  = (dc_reg == DC_W'(SUM_W - 1));
    end

    // Line store port.
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              px_take;

    assign wr_addr = ADDR_W'(ADDR_W'(in_slot_reg) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(in_col_reg);
    assign rd_addr = ADDR_W'(ADDR_W'(win_slot_reg) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(win_x_reg);
    assign px_take = cmd.accept && !in_drain && !in_done_reg;

    always_ff @(posedge clk)
    begin
        if (px_take)
            mem[wr_addr] <= in_pix;
        if (cmd.rd_issue)
            rd_reg <= mem[rd_addr];
    end

    // Division step of each channel.
    logic [CNT_W:0]   rem_sh  [4];
    logic [CNT_W-1:0] rem_nx  [4];
    logic             q_bit   [4];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            rem_sh[c] = {rem_reg[c], dvd_reg[c][SUM_W-1]};
            q_bit[c]  = (rem_sh[c] >= (CNT_W + 1)'(cnt_reg));
            rem_nx[c] = q_bit[c] ? CNT_W'(rem_sh[c] - (CNT_W + 1)'(cnt_reg))
                                 : rem_sh[c][CNT_W-1:0];
        end
    end

    logic out_last;
    assign out_last = (out_row_reg == h_m1) && (out_col_reg == w_m1);

    // Control registers: configuration, positions and division counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg      <= 3'd0;
            fw_reg       <= 11'd1;
            fh_reg       <= 16'd1;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            dc_reg       <= '0;
        end
        else if (cfg_we && (cfg_index == bbc_pkg::CFG_RADIUS || cfg_index == bbc_pkg::CFG_WIDTH
                 || cfg_index == bbc_pkg::CFG_HEIGHT))
        begin
            unique case (cfg_index)
                bbc_pkg::CFG_RADIUS: rad_reg <= cfg_data[2:0];
                bbc_pkg::CFG_WIDTH:  fw_reg  <= cfg_data[10:0];
                default:             fh_reg  <= cfg_data;
            endcase
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            // Input position advances with each stored pixel.
            if (px_take)
            begin
                if (in_col_reg == w_m1)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + 16'd1;
                    in_slot_reg <= (in_slot_reg == SL_W'(LS_ROWS - 1)) ? '0
                                   : in_slot_reg + SL_W'(1);
                    if (in_row_reg == h_m1)
                        in_done_reg <= 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            // Division counter.
            if (cmd.div_start)
                dc_reg <= '0;
            else if (cmd.div_step)
                dc_reg <= dc_reg + DC_W'(1);
            // Output position advances with each delivered beat.
            if (cmd.out_fire)
            begin
                if (out_last)
                begin
                    in_row_reg   <= '0;
                    in_col_reg   <= '0;
                    in_slot_reg  <= '0;
                    in_done_reg  <= 1'b0;
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_slot_reg <= '0;
                end
                else if (out_col_reg == w_m1)
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 16'd1;
                    out_slot_reg <= (out_slot_reg == SL_W'(LS_ROWS - 1)) ? '0
                                    : out_slot_reg + SL_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // Window walk, accumulation and division registers.
    always_ff @(posedge clk)
    begin
        if (cmd.win_start)
        begin
            win_y_reg    <= y0;
            win_x_reg    <= x0;
            win_slot_reg <= slot0;
            ry_reg       <= ry;
            rx_reg       <= rx;
            x0_reg       <= x0;
            cnt_reg      <= '0;
            res_end      <= out_last;
            for (int c = 0; c < 4; c++)
                sum_reg[c] <= '0;
        end
        else if (cmd.acc)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            for (int c = 0; c < 4; c++)
                sum_reg[c] <= sum_reg[c] + SUM_W'(rd_reg[8*c +: 8]);
            if (win_x_reg == rx_reg)
            begin
                win_x_reg    <= x0_reg;
                win_y_reg    <= win_y_reg + 16'd1;
                win_slot_reg <= (win_slot_reg == SL_W'(LS_ROWS - 1)) ? '0
                                : win_slot_reg + SL_W'(1);
            end
            else
            begin
                win_x_reg <= win_x_reg + COL_W'(1);
            end
        end
        if (cmd.div_start)
        begin
            for (int c = 0; c < 4; c++)
            begin
                dvd_reg[c] <= sum_reg[c];
                rem_reg[c] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int c = 0; c < 4; c++)
            begin
                dvd_reg[c] <= {dvd_reg[c][SUM_W-2:0], q_bit[c]};
                rem_reg[c] <= rem_nx[c];
            end
        end
    end

    // Quotients form the result.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            res_pix[8*c +: 8] = dvd_reg[c][7:0];
    end

endmodule

// ----- sv/box_blur_clipped.sv -----
// ----------------------------------------------------------------------------
// Clipped box blur
// RGBA raster-order box filter whose window is clipped at the image edges.
// ----------------------------------------------------------------------------
// One beat is handled at a time. A beat is stored and is checked in the next
// cycle. If the window of the next output pixel is complete, the window is
// walked over the single line-store read port, with a read state and then an
// accumulate state for each window pixel. A one-bit-per-cycle division of all
// four channel sums follows, and then the result is offered until it is
// taken. Any configuration write restarts the frame. The line store needs no
// clearing.
module box_blur_clipped
#(
    parameter int MAX_RADIUS = bbc_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] cfg_data,
    bbc_pix_if.sink                        pix,
    bbc_res_if.source                      res
);

    bbc_pkg::bbc_cmd_t cmd;
    bbc_pkg::bbc_sts_t sts;
    logic [31:0]       res_pix;

    // Controller.
    bbc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    bbc_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_pix    ({pix.pix_alpha, pix.pix_blue, pix.pix_green, pix.pix_red}),
        .in_drain  (pix.drain),
        .cmd       (cmd),
        .sts       (sts),
        .res_pix   (res_pix),
        .res_end   (res.frame_end)
    );

    assign res.out_red   = res_pix[7:0];
    assign res.out_green = res_pix[15:8];
    assign res.out_blue  = res_pix[23:16];
    assign res.out_alpha = res_pix[31:24];

endmodule

// ----- tb/sv/bbc_blur_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box blur result checker
// Follows register writes and accepted pixel beats, works out the clipped
// window mean that each beat releases, and compares every result beat with
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module bbc_blur_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    bbc_pix_if          pix,
    bbc_res_if          res,
    output int          errors,
    output int          pending,
    output bit          frame_busy
);

    localparam int MAX_RADIUS = bbc_pkg::MAX_RADIUS_DEF;
    localparam int MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF;
    localparam int STORE_ROWS = 3 * MAX_RADIUS + 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } blur_px_t;

    logic [31:0]  recent_rows [0:STORE_ROWS*MAX_WIDTH-1];
    int unsigned  radius_reg;
    int unsigned  width_reg;
    int unsigned  height_reg;
    int unsigned  in_row;
    int unsigned  in_col;
    int unsigned  out_row;
    int unsigned  out_col;
    bit           in_done;
    blur_px_t     owed_means[$];

    initial errors = 0;

    function automatic void restart_frame();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
        in_done = 0;
    endfunction

    task automatic report(input string field, input int got, input int want);
        $display("%0t: mismatch on %s, got %0d, wanted %0d", $realtime, field, got, want);
        errors++;
    endtask

    // Store one beat and predict the mean it releases, if any.
    function automatic void blur_beat(input logic [31:0] packed_px, input logic drain);
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int unsigned ry;
        int unsigned rx;
        int unsigned y0;
        int unsigned x0;
        int unsigned cnt;
        int unsigned sum [4];
        logic [31:0] px;
        blur_px_t    mean;
        r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        if (!drain && !in_done)
        begin
            recent_rows[(in_row % STORE_ROWS) * MAX_WIDTH + in_col] = packed_px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                    in_done = 1;
            end
        end
        ry = (out_row + r < h - 1) ? out_row + r : h - 1;
        rx = (out_col + r < w - 1) ? out_col + r : w - 1;
        if (!(in_done || in_row > ry || (in_row == ry && in_col > rx)))
            return;
        y0 = (out_row > r) ? out_row - r : 0;
        x0 = (out_col > r) ? out_col - r : 0;
        foreach (sum[c])
            sum[c] = 0;
        for (int unsigned y = y0; y <= ry; y++)
        begin
            for (int unsigned x = x0; x <= rx; x++)
            begin
                px = recent_rows[(y % STORE_ROWS) * MAX_WIDTH + x];
                for (int c = 0; c < 4; c++)
                    sum[c] += px[8*c +: 8];
            end
        end
        cnt = (ry - y0 + 1) * (rx - x0 + 1);
        mean.red       = 8'(sum[0] / cnt);
        mean.green     = 8'(sum[1] / cnt);
        mean.blue      = 8'(sum[2] / cnt);
        mean.alpha     = 8'(sum[3] / cnt);
        mean.frame_end = (out_row == h - 1) && (out_col == w - 1);
        owed_means.push_back(mean);
        if (mean.frame_end)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // Compare one result beat with the oldest prediction.
    task automatic check_mean();
        blur_px_t want;
        if (owed_means.size() == 0)
        begin
            $display("%0t: result beat with no prediction outstanding", $realtime);
            errors++;
            return;
        end
        want = owed_means.pop_front();
        if (res.out_red !== want.red)
            report("out_red", res.out_red, want.red);
        if (res.out_green !== want.green)
            report("out_green", res.out_green, want.green);
        if (res.out_blue !== want.blue)
            report("out_blue", res.out_blue, want.blue);
        if (res.out_alpha !== want.alpha)
            report("out_alpha", res.out_alpha, want.alpha);
        if (res.frame_end !== want.frame_end)
            report("frame_end", res.frame_end, want.frame_end);
    endtask

    // Results are compared before the same edge's pixel beat is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg = 0;
            width_reg  = 1;
            height_reg = 1;
            restart_frame();
            owed_means.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bbc_pkg::CFG_RADIUS:
                    begin
                        radius_reg = cfg_data[2:0];
                        restart_frame();
                    end
                    bbc_pkg::CFG_WIDTH:
                    begin
                        width_reg = cfg_data[10:0];
                        restart_frame();
                    end
                    bbc_pkg::CFG_HEIGHT:
                    begin
                        height_reg = cfg_data;
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
                check_mean();
            if (pix.valid && pix.ready)
                blur_beat({pix.pix_alpha, pix.pix_blue, pix.pix_green, pix.pix_red}, pix.drain);
        end
        pending    = owed_means.size();
        frame_busy = (in_row != 0) || (in_col != 0) || (out_row != 0) || (out_col != 0)
                     || in_done;
    end

endmodule

// ----- tb/sv/box_blur_clipped_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clipped box blur testbench
// Drives register settings and pixel frames with random gaps and stalls into
// the blur; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module box_blur_clipped_tb;

    localparam int QUIET_CYCLES = 600;
    localparam int STALL_LIMIT  = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          errors;
    int          pending;
    bit          frame_busy;
    bit          steady;
    int          pixels_sent;
    int          stall_cycles;

    bbc_pix_if pix_ch ();
    bbc_res_if res_ch ();

    box_blur_clipped i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_ch),
        .res       (res_ch)
    );

    bbc_blur_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix        (pix_ch),
        .res        (res_ch),
        .errors     (errors),
        .pending    (pending),
        .frame_busy (frame_busy)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result stalls, none during a steady stretch.
    always @(negedge clk)
    begin
        res_ch.ready <= steady || ($urandom_range(99) >= 31);
    end

    // Watchdog on cycles without any beat or register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [7:0] any_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_beat(input logic [31:0] rgba, input logic drain);
        while (!steady && $urandom_range(99) < 31)
        begin
            pix_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.pix_red   <= rgba[7:0];
        pix_ch.pix_green <= rgba[15:8];
        pix_ch.pix_blue  <= rgba[23:16];
        pix_ch.pix_alpha <= rgba[31:24];
        pix_ch.drain     <= drain;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        @(negedge clk);
        if (!drain)
            pixels_sent++;
    endtask

    task automatic send_pixel();
        send_beat({any_byte(), any_byte(), any_byte(), any_byte()}, 1'b0);
    endtask

    // Let every outstanding result arrive, then let the block settle.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic set_frame(input logic [15:0] radius, input logic [15:0] width,
                             input logic [15:0] height);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= bbc_pkg::CFG_RADIUS;
        cfg_data  <= radius;
        @(negedge clk);
        cfg_index <= bbc_pkg::CFG_WIDTH;
        cfg_data  <= width;
        @(negedge clk);
        cfg_index <= bbc_pkg::CFG_HEIGHT;
        cfg_data  <= height;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // One full frame, with stray drains inside and mixed flush beats after.
    task automatic run_frame(input int width, input int height);
        int count;
        count = width * height;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_beat(32'($urandom), 1'b1);
            send_pixel();
        end
        while (frame_busy)
            send_beat({any_byte(), any_byte(), any_byte(), any_byte()},
                      $urandom_range(2) != 0);
    endtask

    initial
    begin
        int w;
        int h;
        int frames;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = bbc_pkg::CFG_RADIUS;
        cfg_data     = '0;
        steady       = 1'b0;
        pixels_sent  = 0;
        stall_cycles = 0;
        pix_ch.valid     = 1'b0;
        pix_ch.pix_red   = '0;
        pix_ch.pix_green = '0;
        pix_ch.pix_blue  = '0;
        pix_ch.pix_alpha = '0;
        pix_ch.drain     = 1'b0;
        res_ch.ready     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single pixel at reset settings, then a drain with nothing owed.
        send_beat(32'hFFFF_FFFF, 1'b0);
        wait_idle();
        send_beat(32'h0000_0000, 1'b1);

        // Widest radius over a window larger than the image.
        set_frame(16'd7, 16'd3, 16'd3);
        for (int i = 0; i < 9; i++)
            send_beat((i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 1'b0);
        while (frame_busy)
            send_beat(32'hFFFF_FFFF, 1'b0);

        // Zero width and height read as one.
        set_frame(16'd0, 16'd0, 16'd0);
        send_beat(32'h8001_FE7F, 1'b0);

        // Width and height registers at their top; the frame is cut short.
        set_frame(16'd0, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_pixel();

        // Random frames, with one stretch free of gaps and stalls.
        frames = 0;
        while (pixels_sent < 900)
        begin
            steady = (frames >= 12) && (frames < 18);
            if ($urandom_range(9) == 0)
            begin
                w = $urandom_range(13, 40);
                h = $urandom_range(1, 2);
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
            end
            set_frame(($urandom_range(3) == 0) ? 16'd7 : 16'($urandom_range(3)),
                      16'(w), 16'(h));
            if ($urandom_range(15) == 0)
            begin
                // Abandon a frame part way; the next write restarts it.
                for (int i = 0; i < w; i++)
                    send_pixel();
            end
            else
                run_frame(w, h);
            frames++;
        end
        steady = 1'b0;

        wait_idle();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
